// ===== hw/rtl/sau_pkg.sv =====
package sau_pkg;

  localparam int SLOT_COUNT = 1024;
  localparam int ADDR_W     = $clog2(SLOT_COUNT);
  localparam int WORD_W     = 64;

  // Element width codes held in the configuration register.
  localparam logic [1:0] KIND_INT8  = 2'd0;
  localparam logic [1:0] KIND_INT16 = 2'd1;
  localparam logic [1:0] KIND_INT32 = 2'd2;
  localparam logic [1:0] KIND_INT64 = 2'd3;

  // Operation codes; any code above OP_SET_FIRST acts as a gather.
  localparam logic [2:0] OP_SET       = 3'd0;
  localparam logic [2:0] OP_ADD       = 3'd1;
  localparam logic [2:0] OP_MAX       = 3'd2;
  localparam logic [2:0] OP_MIN       = 3'd3;
  localparam logic [2:0] OP_ADD_ONE   = 3'd4;
  localparam logic [2:0] OP_SET_FIRST = 3'd5;
  localparam logic [2:0] OP_GATHER    = 3'd6;

  typedef logic [1:0] kind_t;

  typedef struct packed {
    logic [2:0]               op;
    logic [9:0]               slot_index;
    logic signed [WORD_W-1:0] in_value;
    logic                     in_is_null;
  } item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] slot_value;
    logic                     slot_is_null;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic              write_en;
    logic [WORD_W-1:0] next_value;
    logic              is_null;
  } upd_t;

  function automatic logic [WORD_W-1:0] sext_elem(input kind_t kind,
                                                  input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] r;
    begin
      case (kind)
        KIND_INT8:  r = {{(WORD_W-8){x[7]}}, x[7:0]};
        KIND_INT16: r = {{(WORD_W-16){x[15]}}, x[15:0]};
        KIND_INT32: r = {{(WORD_W-32){x[31]}}, x[31:0]};
        default:    r = x;
      endcase
      return r;
    end
  endfunction

  // The null sentinel is the minimum of the element type, sign-extended.
  function automatic logic [WORD_W-1:0] sentinel(input kind_t kind);
    logic [WORD_W-1:0] r;
    begin
      r = sext_elem(kind, {1'b0, {(WORD_W-8){1'b0}}, 7'd0} |
                          (WORD_W'(1) << ((WORD_W'(8) << kind) - WORD_W'(1))));
      return r;
    end
  endfunction

endpackage

// ===== hw/rtl/sau_slot_ram.sv =====
module sau_slot_ram (
  input  logic                    clk,
  input  sau_pkg::ram_wr_t        wr,
  input  logic                    rd_en,
  input  logic [sau_pkg::ADDR_W-1:0] rd_addr,
  output logic [sau_pkg::WORD_W-1:0] rd_data
);
  import sau_pkg::*;

  logic [WORD_W-1:0] mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read-before-write: a read at the address being written returns the old word.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/sau_combine.sv =====
module sau_combine (
  input  sau_pkg::kind_t              kind,
  input  logic [2:0]                  op,
  input  logic [sau_pkg::WORD_W-1:0]  cur_word,
  input  logic [sau_pkg::WORD_W-1:0]  in_value,
  input  logic                        in_is_null,
  output sau_pkg::upd_t               upd
);
  import sau_pkg::*;

  logic [WORD_W-1:0] cur;
  logic [WORD_W-1:0] val;
  logic [WORD_W-1:0] null_s;
  logic [WORD_W-1:0] addend;
  logic [WORD_W-1:0] sum;
  logic              val_gt;
  logic              scatter;
  logic [WORD_W-1:0] nxt;

  always_comb begin
    cur     = sext_elem(kind, cur_word);
    val     = sext_elem(kind, in_value);
    null_s  = sentinel(kind);
    // Add and add-one share one adder.
    addend  = (op == OP_ADD_ONE) ? WORD_W'(1) : val;
    sum     = sext_elem(kind, cur + addend);
    val_gt  = $signed(val) > $signed(cur);
    scatter = (op <= OP_SET_FIRST) && !in_is_null;
    nxt     = cur;
    if (scatter) begin
      if (cur == null_s) begin
        nxt = val;
      end else begin
        case (op)
          OP_SET:     nxt = val;
          OP_ADD:     nxt = sum;
          OP_MAX:     nxt = val_gt ? val : cur;
          OP_MIN:     nxt = val_gt ? cur : val;
          OP_ADD_ONE: nxt = sum;
          default:    nxt = cur;
        endcase
      end
    end
    upd.write_en   = scatter;
    upd.next_value = nxt;
    upd.is_null    = (nxt == null_s);
  end

endmodule

// ===== hw/rtl/scatter_aggregate_update_unit.sv =====
// Datapath: the slot word is read at the item transfer; the item waits in the update stage,
// and the updated word is registered as the result when that stage advances.
// Throughput: one item per cycle while results are taken; writes forward to following items.
// Reset: element width returns to int64 and a clearing pass writes the sentinel to all
// SLOT_COUNT slots, one per cycle; items are held off until it ends.
// A configuration transfer starts the same clearing pass with the sentinel of the new width.
module scatter_aggregate_update_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_data,
  input  logic             item_valid,
  output logic             item_ready,
  input  sau_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output sau_pkg::result_t result
);
  import sau_pkg::*;

  // Configuration and clearing pass.
  kind_t             kind;
  logic              clearing;
  logic [ADDR_W-1:0] clear_addr;

  // Update stage: the item whose slot word is arriving from the memory.
  logic              s1_valid;
  item_t             s1_item;
  logic              s1_adv;

  // Last datapath write, forwarded to an item whose read overlapped it.
  logic              fwd_valid;
  logic [ADDR_W-1:0] fwd_addr;
  logic [WORD_W-1:0] fwd_data;

  logic              item_xfer;
  logic [ADDR_W-1:0] rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic [WORD_W-1:0] cur_word;
  logic [ADDR_W-1:0] s1_addr;
  ram_wr_t           wr;
  upd_t              upd;

  // Configuration is always taken; the contract keeps it to idle periods.
  assign cfg_ready = 1'b1;

  assign s1_adv     = s1_valid && (!result_valid || result_ready);
  assign item_ready = !clearing && (!s1_valid || s1_adv);
  assign item_xfer  = item_valid && item_ready;

  // The slot index wraps to the store depth.
  assign rd_addr = item.slot_index[ADDR_W-1:0];
  assign s1_addr = s1_item.slot_index[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      kind       <= KIND_INT64;
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (cfg_valid && cfg_ready) begin
      kind       <= cfg_data;
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + ADDR_W'(1);
      if (clear_addr == ADDR_W'(SLOT_COUNT - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_xfer) begin
      s1_item <= item;
    end
  end

  // The memory word is stale when the previous write hit the same slot in the
  // cycle this item's read was issued, so the forwarded word wins on a match.
  assign cur_word = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : rd_data;

  sau_combine u_combine (
    .kind       (kind),
    .op         (s1_item.op),
    .cur_word   (cur_word),
    .in_value   (s1_item.in_value),
    .in_is_null (s1_item.in_is_null),
    .upd        (upd)
  );

  always_comb begin
    if (clearing) begin
      wr.en   = 1'b1;
      wr.addr = clear_addr;
      wr.data = sentinel(kind);
    end else begin
      wr.en   = s1_adv && upd.write_en;
      wr.addr = s1_addr;
      wr.data = upd.next_value;
    end
  end

  sau_slot_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (item_xfer),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst || clearing) begin
      fwd_valid <= 1'b0;
    end else if (wr.en) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      fwd_addr <= wr.addr;
      fwd_data <= wr.data;
    end
  end

  // Output register separates the update stage from the consumer.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result.slot_value   <= upd.next_value;
      result.slot_is_null <= upd.is_null;
    end
  end

  a_cfg_starts_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> clearing && clear_addr == '0)
    else $error("configuration transfer did not restart the clearing pass");

  a_item_enters_stage: assert property (@(posedge clk) disable iff (rst)
    item_xfer |=> s1_valid)
    else $error("accepted item did not reach the update stage");

  a_stage_to_result: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> result_valid)
    else $error("update stage advanced without loading a result");

  a_written_word_returned: assert property (@(posedge clk) disable iff (rst)
    s1_adv && !clearing |=> result.slot_value == $past(wr.data) || !$past(wr.en))
    else $error("result differs from the word written back");

endmodule
